// ===== hw/rtl/lhs_pkg.sv =====
// Shared types and constants of the luma histogram statistics block.
`timescale 1ns / 1ps
package lhs_pkg;

    // Defaults of the top-level parameters
    localparam int LHS_NUM_BINS   = 60;
    localparam int LHS_COUNT_BITS = 30;
    localparam int QUEUE_DEPTH    = 4;

    // Field widths
    localparam int PIX_W       = 8;
    localparam int LUMA_W      = 22;
    localparam int BIN_W       = 7;   // bin code 0..NUM_BINS (0..60 by default), the top code is full white
    localparam int BIN_OUT_W   = 6;
    localparam int TOTAL_OUT_W = 30;
    localparam int MEAN_W      = 16;
    localparam int SUM_W       = 38;
    localparam int DIM_W       = 15;
    localparam int AREA_W      = 30;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Rec.709 weights scaled by 10000; full white sums to LUMA_FULL
    localparam logic [LUMA_W-1:0] LUMA_FULL    = 22'd2550000;
    localparam logic [LUMA_W-1:0] WEIGHT_RED   = 22'd2126;
    localparam logic [LUMA_W-1:0] WEIGHT_GREEN = 22'd7152;
    localparam logic [LUMA_W-1:0] WEIGHT_BLUE  = 22'd722;

    // Result kinds
    localparam logic KIND_BIN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Classified pixel, front to back
    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [LUMA_W-1:0] luma;
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic              last;
    } t_pix_item;

    // One result item
    typedef struct packed {
        logic                   item_kind;
        logic [BIN_OUT_W-1:0]   bin_number;
        logic [TOTAL_OUT_W-1:0] bin_total;
        logic [LUMA_W-1:0]      luma_min;
        logic [LUMA_W-1:0]      luma_max;
        logic [MEAN_W-1:0]      mean_red;
        logic [MEAN_W-1:0]      mean_green;
        logic [MEAN_W-1:0]      mean_blue;
        logic                   run_end;
    } t_result;

endpackage

// ===== hw/rtl/lhs_ifs.sv =====
// Pixel and result channel interfaces.
`timescale 1ns / 1ps
interface lhs_pix_if;
    import lhs_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             final_pixel;

    modport source (output valid, red, green, blue, final_pixel, input ready);
    modport sink   (input valid, red, green, blue, final_pixel, output ready);
endinterface

interface lhs_res_if;
    import lhs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   item_kind;
    logic [BIN_OUT_W-1:0]   bin_number;
    logic [TOTAL_OUT_W-1:0] bin_total;
    logic [LUMA_W-1:0]      luma_min;
    logic [LUMA_W-1:0]      luma_max;
    logic [MEAN_W-1:0]      mean_red;
    logic [MEAN_W-1:0]      mean_green;
    logic [MEAN_W-1:0]      mean_blue;
    logic                   run_end;

    modport source (output valid, item_kind, bin_number, bin_total, luma_min, luma_max,
                    mean_red, mean_green, mean_blue, run_end, input ready);
    modport sink   (input valid, item_kind, bin_number, bin_total, luma_min, luma_max,
                    mean_red, mean_green, mean_blue, run_end, output ready);
endinterface

// ===== hw/rtl/lhs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lhs_ram #(
    parameter int WIDTH = lhs_pkg::LHS_COUNT_BITS,
    parameter int DEPTH = lhs_pkg::LHS_NUM_BINS
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/lhs_front.sv =====
// Front end: luma per pixel and its histogram bin, two register stages.
`timescale 1ns / 1ps
module lhs_front #(
    parameter int NUM_BINS = lhs_pkg::LHS_NUM_BINS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lhs_pix_if.sink             i_pix,
    input  logic                i_push_ready,
    output logic                o_push_valid,
    output lhs_pkg::t_pix_item  o_push_item
);
    import lhs_pkg::*;

    // bin = floor(luma * NUM_BINS / LUMA_FULL) as a multiply by a rounded-up
    // reciprocal; the shift keeps luma_max * LUMA_FULL below 2^shift, so it is exact
    localparam int RecipShift = 43;
    localparam int RecipW     = 28;
    localparam int ProdW      = LUMA_W + RecipW;
    localparam logic [63:0] RecipNum =
        (64'(NUM_BINS) << RecipShift) + 64'(LUMA_FULL) - 64'd1;
    localparam logic [RecipW-1:0] BinRecip = RecipW'(RecipNum / 64'(LUMA_FULL));

    logic              en;
    logic [LUMA_W-1:0] n_luma;
    logic [ProdW-1:0]  prod;

    logic              r_a_valid;
    logic [LUMA_W-1:0] r_a_luma;
    logic [PIX_W-1:0]  r_a_red;
    logic [PIX_W-1:0]  r_a_green;
    logic [PIX_W-1:0]  r_a_blue;
    logic              r_a_last;
    logic              r_b_valid;
    t_pix_item         r_b_item;

    // whole pipe moves when the last stage is empty or drains into the queue
    assign en          = !r_b_valid || i_push_ready;
    assign i_pix.ready = en;

    assign n_luma = LUMA_W'(i_pix.red) * WEIGHT_RED
                  + LUMA_W'(i_pix.green) * WEIGHT_GREEN
                  + LUMA_W'(i_pix.blue) * WEIGHT_BLUE;

    assign prod = ProdW'(r_a_luma) * ProdW'(BinRecip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_pix.valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_luma       <= n_luma;
            r_a_red        <= i_pix.red;
            r_a_green      <= i_pix.green;
            r_a_blue       <= i_pix.blue;
            r_a_last       <= i_pix.final_pixel;
            r_b_item.bin   <= prod[RecipShift +: BIN_W];
            r_b_item.luma  <= r_a_luma;
            r_b_item.red   <= r_a_red;
            r_b_item.green <= r_a_green;
            r_b_item.blue  <= r_a_blue;
            r_b_item.last  <= r_a_last;
        end
    end

    assign o_push_valid = r_b_valid;
    assign o_push_item  = r_b_item;
endmodule

// ===== hw/rtl/lhs_queue.sv =====
// Short FIFO of classified pixels between front and back.
`timescale 1ns / 1ps
module lhs_queue #(
    parameter int DEPTH = lhs_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  lhs_pkg::t_pix_item  i_push_item,
    output logic                o_pop_valid,
    input  logic                i_pop,
    output lhs_pkg::t_pix_item  o_pop_item
);
    import lhs_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    t_pix_item       r_slot [DEPTH];
    logic [PtrW-1:0] r_wp;
    logic [PtrW-1:0] r_rp;
    logic [CntW-1:0] r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CntW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_item   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_item;
        end
    end

    // pointers wrap at the last slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == LastPtr) ? '0 : r_wp + PtrW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == LastPtr) ? '0 : r_rp + PtrW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CntW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end
endmodule

// ===== hw/rtl/lhs_div.sv =====
// Restoring divider: 8.8 mean of a channel sum over the pixel count, 16 steps.
`timescale 1ns / 1ps
module lhs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lhs_pkg::SUM_W-1:0]   i_sum,
    input  logic [lhs_pkg::AREA_W-1:0]  i_area,
    output logic                        o_done,
    output logic [lhs_pkg::MEAN_W-1:0]  o_quot
);
    import lhs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [3:0]        r_step;
    logic              r_sat;
    logic [AREA_W-1:0] r_area;
    logic [AREA_W-1:0] r_rem;
    logic [MEAN_W-1:0] r_dq;      // low dividend bits in, quotient bits out
    logic [AREA_W:0]   shifted;
    logic              ge;

    assign shifted = {r_rem, r_dq[MEAN_W-1]};
    assign ge      = (shifted >= {1'b0, r_area});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == 4'd0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_step == 4'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient of (sum << 8) / area; it overflows 16 bits when sum >= 256 * area
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= 4'd15;
            r_area <= i_area;
            r_sat  <= (i_area == '0) || (i_sum >= {i_area, 8'h00});
            r_rem  <= i_sum[SUM_W-1:8];
            r_dq   <= {i_sum[7:0], 8'h00};
        end else if (r_busy) begin
            r_step <= r_step - 4'd1;
            r_rem  <= ge ? AREA_W'(shifted - {1'b0, r_area}) : shifted[AREA_W-1:0];
            r_dq   <= {r_dq[MEAN_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? '1 : r_dq;
endmodule

// ===== hw/rtl/lhs_back.sv =====
// Back end: histogram update, running stats, bin drain and summary output.
`timescale 1ns / 1ps
module lhs_back #(
    parameter int NUM_BINS   = lhs_pkg::LHS_NUM_BINS,
    parameter int COUNT_BITS = lhs_pkg::LHS_COUNT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_pop_valid,
    output logic                       o_pop,
    input  lhs_pkg::t_pix_item         i_pop_item,
    input  logic [lhs_pkg::DIM_W-1:0]  i_image_width,
    input  logic [lhs_pkg::DIM_W-1:0]  i_image_height,
    lhs_res_if.source                  o_res
);
    import lhs_pkg::*;

    localparam int IdxW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;
    localparam logic [BIN_W-1:0]      BinFull  = BIN_W'(NUM_BINS);
    localparam logic [IdxW-1:0]       LastIdx  = IdxW'(NUM_BINS - 1);

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_FLUSH = 3'd1;
    localparam logic [2:0] ST_DRD   = 3'd2;
    localparam logic [2:0] ST_DLD   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SUMM  = 3'd5;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [PIX_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W + 1)'(v);
        return t[SUM_W] ? '1 : t[SUM_W-1:0];
    endfunction

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [IdxW-1:0]       r_k;
    logic [1:0]            r_ch;
    logic                  r_div_busy;

    logic                  r_u_valid;
    logic                  r_u_hit;
    logic [IdxW-1:0]       r_u_idx;
    logic                  r_rvalid;
    logic                  r_fwd_valid;
    logic [IdxW-1:0]       r_fwd_idx;
    logic [COUNT_BITS-1:0] r_fwd_cnt;
    logic [NUM_BINS-1:0]   r_hvalid;
    logic [NUM_BINS-1:0]   n_hvalid;

    logic [SUM_W-1:0]      r_sum_red;
    logic [SUM_W-1:0]      r_sum_green;
    logic [SUM_W-1:0]      r_sum_blue;
    logic [LUMA_W-1:0]     r_lum_min;
    logic [LUMA_W-1:0]     r_lum_max;
    logic [SUM_W-1:0]      r_snap_red;
    logic [SUM_W-1:0]      r_snap_green;
    logic [SUM_W-1:0]      r_snap_blue;
    logic [LUMA_W-1:0]     r_snap_min;
    logic [LUMA_W-1:0]     r_snap_max;
    logic [AREA_W-1:0]     r_area;
    logic [MEAN_W-1:0]     r_mean_red;
    logic [MEAN_W-1:0]     r_mean_green;
    logic [MEAN_W-1:0]     r_mean_blue;

    logic                  r_out_valid;
    t_result               r_out;
    t_result               n_out;

    logic                  pop;
    logic                  pop_hit;
    logic                  drain_rd;
    logic                  ram_re;
    logic [IdxW-1:0]       ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  fwd_hit;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  upd;
    logic                  out_free;
    logic                  out_load;
    logic [COUNT_BITS-1:0] bin_cnt;
    logic [31:0]           bin_cnt_ext;
    logic [SUM_W-1:0]      n_sum_red;
    logic [SUM_W-1:0]      n_sum_green;
    logic [SUM_W-1:0]      n_sum_blue;
    logic [LUMA_W-1:0]     n_lum_min;
    logic [LUMA_W-1:0]     n_lum_max;
    logic                  div_start;
    logic                  div_done;
    logic [MEAN_W-1:0]     div_quot;
    logic [SUM_W-1:0]      div_sum;

    // pixels are taken only while running; a full-white pixel skips the histogram
    assign pop      = (r_state == ST_RUN) && i_pop_valid;
    assign pop_hit  = (i_pop_item.bin != BinFull);
    assign o_pop    = pop;
    assign drain_rd = (r_state == ST_DRD);

    // histogram memory: read on pop or drain step, a pop's count written back in the next cycle
    assign ram_re    = drain_rd || (pop && pop_hit);
    assign ram_raddr = drain_rd ? r_k : i_pop_item.bin[IdxW-1:0];

    lhs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (upd),
        .i_waddr (r_u_idx),
        .i_wdata (new_cnt),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // same bin twice in a row: the read missed last cycle's write, forward it
    assign fwd_hit = r_fwd_valid && (r_fwd_idx == r_u_idx);
    assign old_cnt = fwd_hit ? r_fwd_cnt : (r_rvalid ? ram_rdata : '0);
    assign new_cnt = (old_cnt == CountMax) ? old_cnt : old_cnt + COUNT_BITS'(1);
    assign upd     = r_u_valid && r_u_hit;

    // per-bin valid flags stand in for clearing the memory
    always_comb begin
        n_hvalid = r_hvalid;
        if (upd) begin
            n_hvalid[r_u_idx] = 1'b1;
        end
        if (drain_rd) begin
            n_hvalid[r_k] = 1'b0;
        end
    end

    // running stats
    assign n_sum_red   = sat_add(r_sum_red, i_pop_item.red);
    assign n_sum_green = sat_add(r_sum_green, i_pop_item.green);
    assign n_sum_blue  = sat_add(r_sum_blue, i_pop_item.blue);
    assign n_lum_min   = (i_pop_item.luma < r_lum_min) ? i_pop_item.luma : r_lum_min;
    assign n_lum_max   = (i_pop_item.luma > r_lum_max) ? i_pop_item.luma : r_lum_max;

    // shared divider, one channel at a time
    always_comb begin
        case (r_ch)
            CH_RED:   div_sum = r_snap_red;
            CH_GREEN: div_sum = r_snap_green;
            default:  div_sum = r_snap_blue;
        endcase
    end

    assign div_start = (r_state == ST_DIV) && !r_div_busy;

    lhs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (div_sum),
        .i_area  (r_area),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // output register
    assign out_free    = !r_out_valid || o_res.ready;
    assign out_load    = out_free && ((r_state == ST_DLD) || (r_state == ST_SUMM));
    assign bin_cnt     = r_rvalid ? ram_rdata : '0;
    assign bin_cnt_ext = 32'(bin_cnt);

    always_comb begin
        n_out = '0;
        if (r_state == ST_SUMM) begin
            n_out.item_kind  = KIND_SUMMARY;
            n_out.luma_min   = r_snap_min;
            n_out.luma_max   = r_snap_max;
            n_out.mean_red   = r_mean_red;
            n_out.mean_green = r_mean_green;
            n_out.mean_blue  = r_mean_blue;
            n_out.run_end    = 1'b1;
        end else begin
            n_out.item_kind  = KIND_BIN;
            n_out.bin_number = BIN_OUT_W'(r_k);
            n_out.bin_total  = bin_cnt_ext[TOTAL_OUT_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (pop && i_pop_item.last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: n_state = ST_DRD;
            ST_DRD:   n_state = ST_DLD;
            ST_DLD: begin
                if (out_free) begin
                    n_state = (r_k == LastIdx) ? ST_DIV : ST_DRD;
                end
            end
            ST_DIV: begin
                if (r_div_busy && div_done && (r_ch == CH_BLUE)) begin
                    n_state = ST_SUMM;
                end
            end
            ST_SUMM: begin
                if (out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // control state and live stats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_k         <= '0;
            r_ch        <= CH_RED;
            r_div_busy  <= 1'b0;
            r_u_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_hvalid    <= '0;
            r_sum_red   <= '0;
            r_sum_green <= '0;
            r_sum_blue  <= '0;
            r_lum_min   <= LUMA_FULL;
            r_lum_max   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_u_valid   <= pop;
            r_fwd_valid <= upd;
            r_hvalid    <= n_hvalid;

            if (pop) begin
                if (i_pop_item.last) begin
                    r_sum_red   <= '0;
                    r_sum_green <= '0;
                    r_sum_blue  <= '0;
                    r_lum_min   <= LUMA_FULL;
                    r_lum_max   <= '0;
                end else begin
                    r_sum_red   <= n_sum_red;
                    r_sum_green <= n_sum_green;
                    r_sum_blue  <= n_sum_blue;
                    r_lum_min   <= n_lum_min;
                    r_lum_max   <= n_lum_max;
                end
            end

            if (r_state == ST_FLUSH) begin
                r_k <= '0;
            end else if ((r_state == ST_DLD) && out_free && (r_k != LastIdx)) begin
                r_k <= r_k + IdxW'(1);
            end

            if ((r_state == ST_DLD) && out_free) begin
                r_ch       <= CH_RED;
                r_div_busy <= 1'b0;
            end else if (div_start) begin
                r_div_busy <= 1'b1;
            end else if ((r_state == ST_DIV) && div_done) begin
                r_div_busy <= 1'b0;
                if (r_ch != CH_BLUE) begin
                    r_ch <= r_ch + 2'd1;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_u_hit <= pop_hit;
            r_u_idx <= i_pop_item.bin[IdxW-1:0];
        end
        if (ram_re) begin
            r_rvalid <= r_hvalid[ram_raddr];
        end
        if (upd) begin
            r_fwd_idx <= r_u_idx;
            r_fwd_cnt <= new_cnt;
        end
        if (pop && i_pop_item.last) begin
            r_snap_red   <= n_sum_red;
            r_snap_green <= n_sum_green;
            r_snap_blue  <= n_sum_blue;
            r_snap_min   <= n_lum_min;
            r_snap_max   <= n_lum_max;
        end
        if (r_state == ST_FLUSH) begin
            r_area <= AREA_W'(i_image_width) * AREA_W'(i_image_height);
        end
        if ((r_state == ST_DIV) && r_div_busy && div_done) begin
            case (r_ch)
                CH_RED:   r_mean_red   <= div_quot;
                CH_GREEN: r_mean_green <= div_quot;
                default:  r_mean_blue  <= div_quot;
            endcase
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.item_kind  = r_out.item_kind;
    assign o_res.bin_number = r_out.bin_number;
    assign o_res.bin_total  = r_out.bin_total;
    assign o_res.luma_min   = r_out.luma_min;
    assign o_res.luma_max   = r_out.luma_max;
    assign o_res.mean_red   = r_out.mean_red;
    assign o_res.mean_green = r_out.mean_green;
    assign o_res.mean_blue  = r_out.mean_blue;
    assign o_res.run_end    = r_out.run_end;
endmodule

// ===== hw/rtl/luma_histogram_stats.sv =====
// Top level of the luma histogram statistics block.
`timescale 1ns / 1ps
//
//  Channel  Dir  Handshake            Payload
//  i_pix    in   valid/ready          red, green, blue, final_pixel
//  o_res    out  valid/ready          item_kind, bin_number, bin_total, luma_min,
//                                     luma_max, mean_red/green/blue, run_end
//  i_cfg_*  in   write enable only    index 0 image_width, index 1 image_height
//
//  One pixel per cycle while the back end is running and the queue has room; each pixel passes
//  the luma and bin front stages to the queue. After the final pixel the back end drains the
//  histogram memory, reading each bin, then loading it out as output stalls allow; it runs three
//  16-step divisions in its one divider and sends the summary; pixels still enter until the queue fills.
//  Reset clears per-bin valid flags and the stats at once; there is no clearing pass.
//  Input ready drops only while the four-entry queue and the last front stage are full.
module luma_histogram_stats #(
    parameter int NUM_BINS   = lhs_pkg::LHS_NUM_BINS,
    parameter int COUNT_BITS = lhs_pkg::LHS_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lhs_pix_if.sink                        i_pix,
    lhs_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [lhs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lhs_pkg::DIM_W-1:0]      i_cfg_data
);
    import lhs_pkg::*;

    logic [DIM_W-1:0] r_image_width;
    logic [DIM_W-1:0] r_image_height;
    logic             push_valid;
    logic             push_ready;
    t_pix_item        push_item;
    logic             pop_valid;
    logic             pop;
    t_pix_item        pop_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_W'(1);
            r_image_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lhs_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_item  (push_item)
    );

    lhs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_item   (pop_item)
    );

    lhs_back #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (pop_valid),
        .o_pop          (pop),
        .i_pop_item     (pop_item),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_res          (o_res)
    );
endmodule
